>>> hdl/hmbf_pkg.sv
package hmbf_pkg;

	localparam int LENGTH_BITS_DEF = 32;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       accepted;
		logic       in_body;
		logic       message_complete;
	} out_item_t;

	typedef enum logic [2:0] {
		PH_HEADER      = 3'd0,
		PH_CHUNK_SIZE  = 3'd1,
		PH_CHUNK_DATA  = 3'd2,
		PH_LENGTH_BODY = 3'd3,
		PH_DONE        = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_CLEN    = 2'd1,
		KIND_TENC    = 2'd2,
		KIND_OTHER   = 2'd3
	} kind_t;

	localparam logic [4:0] CLEN_NAME_LEN    = 5'd15;
	localparam logic [4:0] TENC_NAME_LEN    = 5'd18;
	localparam logic [2:0] CHUNKED_WORD_LEN = 3'd7;
	localparam logic [7:0] CHAR_CR  = 8'h0D;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_SP  = 8'h20;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	// lower-case header name characters
	function automatic logic [7:0] clen_char(input logic [4:0] i);
		case (i)
			5'd0: clen_char = "c";  5'd1: clen_char = "o";  5'd2: clen_char = "n";
			5'd3: clen_char = "t";  5'd4: clen_char = "e";  5'd5: clen_char = "n";
			5'd6: clen_char = "t";  5'd7: clen_char = "-";  5'd8: clen_char = "l";
			5'd9: clen_char = "e";  5'd10: clen_char = "n"; 5'd11: clen_char = "g";
			5'd12: clen_char = "t"; 5'd13: clen_char = "h"; 5'd14: clen_char = ":";
			default: clen_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] tenc_char(input logic [4:0] i);
		case (i)
			5'd0: tenc_char = "t";  5'd1: tenc_char = "r";  5'd2: tenc_char = "a";
			5'd3: tenc_char = "n";  5'd4: tenc_char = "s";  5'd5: tenc_char = "f";
			5'd6: tenc_char = "e";  5'd7: tenc_char = "r";  5'd8: tenc_char = "-";
			5'd9: tenc_char = "e";  5'd10: tenc_char = "n"; 5'd11: tenc_char = "c";
			5'd12: tenc_char = "o"; 5'd13: tenc_char = "d"; 5'd14: tenc_char = "i";
			5'd15: tenc_char = "n"; 5'd16: tenc_char = "g"; 5'd17: tenc_char = ":";
			default: tenc_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] chunked_char(input logic [2:0] i);
		case (i)
			3'd0: chunked_char = "c"; 3'd1: chunked_char = "h"; 3'd2: chunked_char = "u";
			3'd3: chunked_char = "n"; 3'd4: chunked_char = "k"; 3'd5: chunked_char = "e";
			3'd6: chunked_char = "d";
			default: chunked_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		to_lower = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

endpackage

>>> hdl/http_message_body_framer.sv
// HTTP message body framer, one byte per request.
// Path: an accepted request passes the input register, then the result register, before result valid.
// Throughput: one byte per cycle while out_stall is low; the per-byte state update fits between the two registers.
// Reset: arst_n clears framing state, framing_enable and both valid flags asynchronously.
module http_message_body_framer
	import hmbf_pkg::*;
#(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	localparam int LB = LENGTH_BITS;
	localparam logic [LB-1:0] LMAX = {LB{1'b1}};

	logic          framing_enable_q;
	in_item_t      in_s1;
	logic          valid_s1;
	logic          valid_s2;
	out_item_t     res_s2;

	phase_t        phase_q;
	logic          chunked_q;
	logic [4:0]    lpos_q;
	kind_t         kind_q;
	logic [2:0]    wpos_q;
	logic          blank_q;
	logic [LB-1:0] clen_q;
	logic [LB-1:0] chlen_q;
	logic [LB:0]   bcount_q;
	logic          nstart_q;

	phase_t        phase_d;
	logic          chunked_d;
	logic [4:0]    lpos_d;
	kind_t         kind_d;
	logic [2:0]    wpos_d;
	logic          blank_d;
	logic [LB-1:0] clen_d;
	logic [LB-1:0] chlen_d;
	logic [LB:0]   bcount_d;
	logic          nstart_d;
	out_item_t     res_d;

	logic          adv_s2;
	logic          adv_s1;

	// stage 1 moves when stage 2 is free or draining
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;
	assign out_valid = valid_s2;
	assign out_item  = res_s2;

	// next-state logic for one byte
	always_comb begin
		logic [7:0]      b;
		logic [7:0]      lc;
		logic            dig;
		logic [3:0]      hv;
		logic            hok;
		logic [LB+4:0]   m10;
		logic [LB+4:0]   m16;
		logic [LB:0]     bc1;
		b   = in_s1.data_byte;
		lc  = to_lower(b);
		dig = (b >= "0" && b <= "9");
		hok = 1'b1;
		hv  = 4'd0;
		if (dig) hv = 4'(b - "0");
		else if (lc >= "a" && lc <= "f") hv = 4'(lc - "a" + 8'd10);
		else hok = 1'b0;
		m10 = {5'd0, clen_q} * (LB+5)'(10) + (LB+5)'(b[3:0]);
		m16 = {1'b0, chlen_q, 4'd0} + (LB+5)'(hv);
		bc1 = bcount_q + 1'b1;

		phase_d = phase_q; chunked_d = chunked_q; lpos_d = lpos_q; kind_d = kind_q;
		wpos_d = wpos_q; blank_d = blank_q; clen_d = clen_q; chlen_d = chlen_q;
		bcount_d = bcount_q; nstart_d = nstart_q;
		res_d.out_byte = b;
		res_d.accepted = 1'b1;
		res_d.in_body = 1'b0;
		res_d.message_complete = 1'b0;

		if (in_s1.opcode) begin
			phase_d = PH_HEADER; chunked_d = 1'b0; clen_d = '0; chlen_d = '0;
			bcount_d = '0; lpos_d = '0; kind_d = KIND_UNKNOWN; wpos_d = '0;
			blank_d = 1'b1; nstart_d = 1'b0;
			res_d.accepted = 1'b0;
		end else if (framing_enable_q) begin
			unique case (phase_q)
				PH_HEADER: begin
					if (b == CHAR_LF) begin
						if (blank_q) begin
							bcount_d = '0;
							if (chunked_q) phase_d = PH_CHUNK_SIZE;
							else if (clen_q == '0) begin
								phase_d = PH_DONE;
								res_d.message_complete = 1'b1;
							end else phase_d = PH_LENGTH_BODY;
						end
						lpos_d = '0; kind_d = KIND_UNKNOWN; wpos_d = '0;
						blank_d = 1'b1; nstart_d = 1'b0;
					end else begin
						if (b != CHAR_CR) blank_d = 1'b0;
						if (kind_q == KIND_UNKNOWN) begin
							if (lc == "c") begin kind_d = KIND_CLEN; lpos_d = 5'd1; end
							else if (lc == "t") begin kind_d = KIND_TENC; lpos_d = 5'd1; end
							else kind_d = KIND_OTHER;
						end else if (kind_q == KIND_CLEN && lpos_q < CLEN_NAME_LEN) begin
							if (lc == clen_char(lpos_q)) lpos_d = lpos_q + 5'd1;
							else kind_d = KIND_OTHER;
						end else if (kind_q == KIND_TENC && lpos_q < TENC_NAME_LEN) begin
							if (lc == tenc_char(lpos_q)) lpos_d = lpos_q + 5'd1;
							else kind_d = KIND_OTHER;
						end else if (kind_q == KIND_CLEN) begin
							if (!nstart_q) begin
								if (dig) begin
									clen_d = LB'(b[3:0]); nstart_d = 1'b1;
								end else if (b != CHAR_SP && b != CHAR_TAB) kind_d = KIND_OTHER;
							end else if (dig) begin
								clen_d = (m10 > (LB+5)'(LMAX)) ? LMAX : m10[LB-1:0];
							end else kind_d = KIND_OTHER;
						end else if (kind_q == KIND_TENC) begin
							if (wpos_q < CHUNKED_WORD_LEN) begin
								if (lc == chunked_char(wpos_q)) begin
									wpos_d = wpos_q + 3'd1;
									if (wpos_q + 3'd1 >= CHUNKED_WORD_LEN) chunked_d = 1'b1;
								end else wpos_d = (lc == "c") ? 3'd1 : 3'd0;
							end
						end
					end
				end
				PH_CHUNK_SIZE: begin
					res_d.in_body = 1'b1;
					if (b == CHAR_LF) begin
						if (nstart_q) begin bcount_d = '0; phase_d = PH_CHUNK_DATA; end
						lpos_d = '0; kind_d = KIND_UNKNOWN; wpos_d = '0;
						blank_d = 1'b1; nstart_d = 1'b0;
					end else if (kind_q != KIND_OTHER) begin
						if (!nstart_q) begin
							if (hok) begin
								chlen_d = LB'(hv); nstart_d = 1'b1;
							end else if (b != CHAR_SP && b != CHAR_TAB) kind_d = KIND_OTHER;
						end else if (hok) begin
							chlen_d = (m16 > (LB+5)'(LMAX)) ? LMAX : m16[LB-1:0];
						end else kind_d = KIND_OTHER;
					end
				end
				PH_CHUNK_DATA: begin
					res_d.in_body = 1'b1;
					bcount_d = bc1;
					if ({1'b0, bc1} >= {2'b00, chlen_q} + (LB+2)'(2)) begin
						bcount_d = '0;
						if (chlen_q == '0) begin
							phase_d = PH_DONE;
							res_d.message_complete = 1'b1;
						end else phase_d = PH_CHUNK_SIZE;
						lpos_d = '0; kind_d = KIND_UNKNOWN; wpos_d = '0;
						blank_d = 1'b1; nstart_d = 1'b0;
					end
				end
				PH_LENGTH_BODY: begin
					res_d.in_body = 1'b1;
					bcount_d = bc1;
					if (bc1 >= {1'b0, clen_q}) begin
						phase_d = PH_DONE;
						res_d.message_complete = 1'b1;
					end
				end
				default: begin
					res_d.accepted = 1'b0;
					res_d.message_complete = 1'b1;
				end
			endcase
		end
	end

	// hold state and pipeline registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			framing_enable_q <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q <= PH_HEADER; chunked_q <= 1'b0; lpos_q <= '0; kind_q <= KIND_UNKNOWN;
			wpos_q <= '0; blank_q <= 1'b1; clen_q <= '0; chlen_q <= '0;
			bcount_q <= '0; nstart_q <= 1'b0;
		end else begin
			if (cfg_we) framing_enable_q <= cfg_data;
			if (!in_stall) begin
				valid_s1 <= in_valid;
				if (in_valid) in_s1 <= in_item;
			end
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s1) begin
				res_s2 <= res_d;
				phase_q <= phase_d; chunked_q <= chunked_d; lpos_q <= lpos_d;
				kind_q <= kind_d; wpos_q <= wpos_d; blank_q <= blank_d;
				clen_q <= clen_d; chlen_q <= chlen_d; bcount_q <= bcount_d;
				nstart_q <= nstart_d;
			end
		end
	end

endmodule

>>> hdl/hmbf_checker.sv
module hmbf_checker
	import hmbf_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// a byte flagged complete but not accepted is held after the message, never body
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.accepted && out_item.message_complete |-> !out_item.in_body)
		else $error("held byte flagged as body");

	// body bytes are always part of the current message
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.in_body |-> out_item.accepted)
		else $error("body byte not accepted");

	// an item taken with no downstream stall passes the input and result registers to the output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
		else $error("result lost");

endmodule

bind http_message_body_framer hmbf_checker u_hmbf_checker (.*);

>>> tb/sv/http_message_body_framer_chk.sv
`timescale 1ns / 100ps

module http_message_body_framer_chk
	import hmbf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_data,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_item,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_item,
	output int        pending,
	output int        fails
);

	localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS_DEF) - 64'd1;
	localparam string CLEN_NAME = "content-length:";
	localparam string TENC_NAME = "transfer-encoding:";
	localparam string CHUNK_WORD = "chunked";

	out_item_t expected_q[$];

	logic            enable;
	phase_t          ph;
	logic            chunked;
	int              name_pos;
	kind_t           kind;
	int              word_pos;
	logic            blank;
	longint unsigned content_len;
	longint unsigned chunk_len;
	longint unsigned body_cnt;
	logic            started;

	assign pending = expected_q.size();

	function automatic logic [7:0] lower(input logic [7:0] b);
		return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
	endfunction

	function automatic int hex_digit(input logic [7:0] b);
		logic [7:0] lc;
		lc = lower(b);
		if (b >= "0" && b <= "9") return b - "0";
		if (lc >= "a" && lc <= "f") return lc - "a" + 10;
		return -1;
	endfunction

	function automatic longint unsigned sat_mac(input longint unsigned v, input int d,
			input int base);
		if (v > (LEN_MAX - d) / base) return LEN_MAX;
		return v * base + d;
	endfunction

	task automatic clear_line();
		name_pos = 0;
		kind = KIND_UNKNOWN;
		word_pos = 0;
		blank = 1'b1;
		started = 1'b0;
	endtask

	task automatic clear_msg();
		ph = PH_HEADER;
		chunked = 1'b0;
		content_len = 0;
		chunk_len = 0;
		body_cnt = 0;
		clear_line();
	endtask

	// match header names and pick up length or chunked coding
	task automatic header_char(input logic [7:0] b);
		logic [7:0] lc;
		logic       dig;
		lc = lower(b);
		dig = (b >= "0" && b <= "9");
		if (b != CHAR_CR) blank = 1'b0;
		if (kind == KIND_UNKNOWN) begin
			if (lc == "c") begin
				kind = KIND_CLEN;
				name_pos = 1;
			end else if (lc == "t") begin
				kind = KIND_TENC;
				name_pos = 1;
			end else kind = KIND_OTHER;
		end else if (kind == KIND_CLEN && name_pos < CLEN_NAME.len()) begin
			if (lc == CLEN_NAME[name_pos]) name_pos++;
			else kind = KIND_OTHER;
		end else if (kind == KIND_TENC && name_pos < TENC_NAME.len()) begin
			if (lc == TENC_NAME[name_pos]) name_pos++;
			else kind = KIND_OTHER;
		end else if (kind == KIND_CLEN) begin
			if (!started) begin
				if (dig) begin
					content_len = b - "0";
					started = 1'b1;
				end else if (b != CHAR_SP && b != CHAR_TAB) kind = KIND_OTHER;
			end else if (dig) content_len = sat_mac(content_len, b - "0", 10);
			else kind = KIND_OTHER;
		end else if (kind == KIND_TENC && word_pos < CHUNK_WORD.len()) begin
			if (lc == CHUNK_WORD[word_pos]) word_pos++;
			else word_pos = (lc == "c") ? 1 : 0;
			if (word_pos >= CHUNK_WORD.len()) chunked = 1'b1;
		end
	endtask

	// parse a chunk-size line
	task automatic size_char(input logic [7:0] b);
		int h;
		h = hex_digit(b);
		if (kind == KIND_OTHER) return;
		if (!started) begin
			if (h >= 0) begin
				chunk_len = h;
				started = 1'b1;
			end else if (b != CHAR_SP && b != CHAR_TAB) kind = KIND_OTHER;
		end else if (h >= 0) chunk_len = sat_mac(chunk_len, h, 16);
		else kind = KIND_OTHER;
	endtask

	// advance the framer state by one request and give its result
	task automatic frame_byte(input in_item_t it, output out_item_t res);
		logic [7:0] b;
		b = it.data_byte;
		res = '{out_byte: b, accepted: 1'b1, in_body: 1'b0, message_complete: 1'b0};
		if (it.opcode) begin
			clear_msg();
			res.accepted = 1'b0;
			return;
		end
		if (!enable) return;
		case (ph)
			PH_HEADER: begin
				if (b == CHAR_LF) begin
					if (blank) begin
						body_cnt = 0;
						if (chunked) ph = PH_CHUNK_SIZE;
						else if (content_len == 0) begin
							ph = PH_DONE;
							res.message_complete = 1'b1;
						end else ph = PH_LENGTH_BODY;
					end
					clear_line();
				end else header_char(b);
			end
			PH_CHUNK_SIZE: begin
				res.in_body = 1'b1;
				if (b == CHAR_LF) begin
					if (started) begin
						body_cnt = 0;
						ph = PH_CHUNK_DATA;
					end
					clear_line();
				end else size_char(b);
			end
			PH_CHUNK_DATA: begin
				res.in_body = 1'b1;
				body_cnt++;
				if (body_cnt >= chunk_len + 2) begin
					body_cnt = 0;
					if (chunk_len == 0) begin
						ph = PH_DONE;
						res.message_complete = 1'b1;
					end else ph = PH_CHUNK_SIZE;
					clear_line();
				end
			end
			PH_LENGTH_BODY: begin
				res.in_body = 1'b1;
				body_cnt++;
				if (body_cnt >= content_len) begin
					ph = PH_DONE;
					res.message_complete = 1'b1;
				end
			end
			default: begin
				res.accepted = 1'b0;
				res.message_complete = 1'b1;
			end
		endcase
	endtask

	task automatic report(input string what, input int got, input int want);
		fails++;
		$display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// watch config, requests and results
	always @(posedge clk or negedge arst_n) begin : watch
		out_item_t res;
		out_item_t want;
		if (!arst_n) begin
			enable = 1'b0;
			clear_msg();
			expected_q.delete();
		end else begin
			if (cfg_we) enable = cfg_data;
			if (in_valid && !in_stall) begin
				frame_byte(in_item, res);
				expected_q.push_back(res);
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result", int'(out_item), 0);
				end else begin
					want = expected_q.pop_front();
					if (out_item.out_byte !== want.out_byte)
						report("out_byte", out_item.out_byte, want.out_byte);
					if (out_item.accepted !== want.accepted)
						report("accepted", out_item.accepted, want.accepted);
					if (out_item.in_body !== want.in_body)
						report("in_body", out_item.in_body, want.in_body);
					if (out_item.message_complete !== want.message_complete)
						report("message_complete", out_item.message_complete,
							want.message_complete);
				end
			end
		end
	end

	initial fails = 0;

endmodule

>>> tb/sv/http_message_body_framer_tb.sv
`timescale 1ns / 100ps

module http_message_body_framer_tb;
	import hmbf_pkg::*;

	localparam int ITEMS = 1200;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 250;
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_NEXT = 1'b1;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic      cfg_data = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_item = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_item;
	int        pending;
	int        fails;
	int        sent = 0;
	int        idle_cycles = 0;
	logic      hold_req = 1'b0;

	http_message_body_framer u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	http_message_body_framer_chk u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.pending(pending), .fails(fails)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stall runs, plus one long hold on request
	initial begin : receiver
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else begin
				n = gap_len();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
					out_stall <= 1'b0;
				end
				repeat ($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(20, 60))
					@(posedge clk);
			end
		end
	end

	// offer one request and hold it until taken
	task automatic send(input logic op, input logic [7:0] b);
		logic stalled;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{opcode: op, data_byte: b};
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		sent++;
	endtask

	function automatic logic [7:0] mixcase(input logic [7:0] b);
		if (b >= "a" && b <= "z" && $urandom_range(0, 1)) return b - 8'd32;
		return b;
	endfunction

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) send(OP_DATA, mixcase(s[i]));
	endtask

	task automatic send_raw(input int n);
		for (int i = 0; i < n; i++) send(OP_DATA, 8'($urandom_range(0, 255)));
	endtask

	// drain, settle, then write the framing enable
	task automatic write_enable(input logic v);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one random message: header lines, blank line, body, trailing bytes, next
	task automatic send_message();
		int mode;
		int len;
		int nchunks;
		mode = $urandom_range(0, 3);
		if ($urandom_range(0, 1)) send_str("host: a.b\r\n");
		if ($urandom_range(0, 3) == 0) send_str("cache-control: no\r\n");
		if ($urandom_range(0, 3) == 0) send_str("te: trailers\r\n");
		len = $urandom_range(0, 20);
		if (mode == 0 || mode == 3) begin
			if ($urandom_range(0, 7) == 0) send_str("content-length: x\r\n");
			send_str($sformatf("content-length:%s%0d\r\n",
				$urandom_range(0, 1) ? " \t" : "", len));
		end
		if (mode == 1 || mode == 3)
			send_str($urandom_range(0, 1) ? "transfer-encoding: chunked\r\n"
				: "transfer-encoding: gzip, cchunked\r\n");
		case ($urandom_range(0, 2))
			0: send_str("\r\n");
			1: send_str("\n");
			default: send_str("\r\r\n");
		endcase
		if (mode == 1 || mode == 3) begin
			nchunks = $urandom_range(0, 3);
			for (int c = 0; c < nchunks; c++) begin
				len = $urandom_range(1, 12);
				if ($urandom_range(0, 5) == 0) send_str("zz\r\n");
				send_str($sformatf(" %0h%s\r\n", len, $urandom_range(0, 3) ? "" : ";ext"));
				send_raw(len);
				send_str("\r\n");
			end
			send_str("0\r\n\r\n");
		end else if (mode == 0) send_raw(len);
		if ($urandom_range(0, 9) == 0) send_raw($urandom_range(1, 8));
		send_raw($urandom_range(0, 3));
		send(OP_NEXT, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unframed pass-through, extremes of the byte
		send(OP_DATA, 8'h00);
		send(OP_DATA, 8'hFF);
		send(OP_NEXT, 8'hA5);
		send_raw(40);
		write_enable(1'b1);

		// saturating length, saturating chunk size, zero length
		send_str("Content-Length: 99999999999\r\n\r\n");
		send_raw(3);
		send(OP_NEXT, 8'h5A);
		send_str("Transfer-Encoding: CHUNKED\r\nContent-Length: 4\r\n\r\nFFFFFFFFFFFF\r\n");
		send_raw(3);
		send(OP_NEXT, 8'h00);
		send_str("content-length: 0\r\n\r\n");
		send(OP_DATA, 8'hFF);
		send(OP_NEXT, 8'hFF);

		// long receiver hold while requests keep coming
		hold_req = 1'b1;
		for (int i = 0; i < 3; i++) send_message();

		for (int p = 0; p < 6; p++) begin
			write_enable(p % 3 != 2);
			while (sent < (p + 1) * ITEMS / 6) begin
				if ($urandom_range(0, 9) == 0) send_raw($urandom_range(1, 10));
				else send_message();
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fails == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
